@@ rtl/jep_pkg.sv @@
package jep_pkg;

  // Field widths of the item and result beats
  localparam int unsigned RING_W  = 7;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned LABEL_W = 7;

endpackage

@@ rtl/jep_ring_ram.sv @@
module jep_ring_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [$clog2(DEPTH)-1:0]   wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [$clog2(DEPTH)-1:0]   rd_data
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/josephus_elimination_order_top.sv @@
// Channel  | Ports                                   | Beat
// ---------+-----------------------------------------+----------------------------
// in       | in_valid, in_stall, in_ring_count,      | one ring: size n, step m
//          | in_step_count                           |
// out      | out_valid, out_stall, out_label,        | one removed label; survivor
//          | out_last                                | carries out_last
//
// Order of work: the sequencer first builds the ring in the store, one
// write per member, then for each of the n - 1 removals issues one read,
// makes m pointer hops (0 counts as 1) and relinks around the victim.
// The single read port of the ring store allows one hop per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register. in_stall is high for the whole item; a stalled
// output beat holds the sequencer once its next beat is due, until taken.
module josephus_elimination_order_top #(
  parameter int unsigned RING_SIZE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jep_pkg::RING_W-1:0]    in_ring_count,
  input  logic [jep_pkg::STEP_W-1:0]    in_step_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jep_pkg::LABEL_W-1:0]   out_label,
  output logic                          out_last
);

  import jep_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_SIZE);
  localparam int unsigned CNT_W = $clog2(RING_SIZE + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_LINK = 3'd4;
  localparam logic [2:0] ST_LAST = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   ring_n_r, ring_n_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   victim_r, victim_nxt;
  logic [STEP_W-1:0]  step_hops_r, step_hops_nxt;
  logic [STEP_W-1:0]  hops_r, hops_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r, out_label_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_take;
  logic               out_free;
  logic [RING_W-1:0]  ring_sat;
  logic [IDX_W-1:0]   last_idx;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   rd_data;

  jep_ring_ram #(
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign ring_sat = (in_ring_count > RING_W'(RING_SIZE)) ? RING_W'(RING_SIZE) : in_ring_count;
  assign last_idx = IDX_W'(ring_n_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    ring_n_nxt    = ring_n_r;
    rem_nxt       = rem_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    victim_nxt    = victim_r;
    step_hops_nxt = step_hops_r;
    hops_nxt      = hops_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = fill_r;
    wr_data       = (fill_r == last_idx) ? '0 : IDX_W'(fill_r + IDX_W'(1));
    rd_addr       = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take && (ring_sat != '0)) begin
          ring_n_nxt    = CNT_W'(ring_sat);
          fill_nxt      = '0;
          step_hops_nxt = (in_step_count == '0) ? '0 : in_step_count - STEP_W'(1);
          state_nxt     = ST_FILL;
        end
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (fill_r == last_idx) begin
          pos_nxt   = last_idx;
          rem_nxt   = ring_n_r;
          state_nxt = (ring_n_r == CNT_W'(1)) ? ST_LAST : ST_RD;
        end else begin
          fill_nxt = IDX_W'(fill_r + IDX_W'(1));
        end
      end
      ST_RD: begin
        rd_addr   = pos_r;
        hops_nxt  = step_hops_r;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // rd_data holds the successor of pos_r; chase it either way
        rd_addr = rd_data;
        if (hops_r != '0) begin
          pos_nxt  = rd_data;
          hops_nxt = hops_r - STEP_W'(1);
        end else begin
          victim_nxt = rd_data;
          state_nxt  = ST_LINK;
        end
      end
      ST_LINK: begin
        // keep reading the victim's successor while the output is held
        rd_addr = victim_r;
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r;
          wr_data       = rd_data;
          out_valid_nxt = 1'b1;
          out_label_nxt = LABEL_W'(victim_r) + LABEL_W'(1);
          out_last_nxt  = 1'b0;
          rem_nxt       = rem_r - CNT_W'(1);
          state_nxt     = (rem_r == CNT_W'(2)) ? ST_LAST : ST_RD;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = LABEL_W'(pos_r) + LABEL_W'(1);
          out_last_nxt  = 1'b1;
          rem_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ring_n_r    <= ring_n_nxt;
    fill_r      <= fill_nxt;
    victim_r    <= victim_nxt;
    step_hops_r <= step_hops_nxt;
    hops_r      <= hops_nxt;
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_label = out_label_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/jep_checker.sv @@
module jep_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [jep_pkg::RING_W-1:0]   in_ring_count,
  input logic [jep_pkg::STEP_W-1:0]   in_step_count,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [jep_pkg::LABEL_W-1:0]  out_label,
  input logic                         out_last
);

  import jep_pkg::*;

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_label) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A non-empty ring keeps the input side busy from the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_ring_count != '0) |=> in_stall)
    else $error("input taken again before the ring was worked through");

  // A fresh result beat only appears while an item is in progress
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared with no item in progress");

  // A removal never carries label zero
  a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_label != '0))
    else $error("result beat with label zero");

endmodule

bind josephus_elimination_order_top jep_checker u_jep_checker (.*);
